/* rtl/abe_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the allocation bitmap engine: capacity, request codes
// and status codes. No dependencies.
package abe_pkg;

    localparam int MAX_BYTES = 64;
    localparam int ADDR_W    = $clog2(MAX_BYTES);
    localparam int POS_W     = 9;
    localparam int SIZE_W    = 7;

    localparam logic [1:0] REQ_FIND  = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_TEST  = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_ERROR     = 2'd2;

    localparam logic REG_BYTES_IN_USE = 1'b0;

endpackage

/* rtl/allocation_bitmap_engine_core.sv */
`timescale 1ns / 1ps
// Allocation bitmap engine top level: bitmap memory, scan sequencer and
// register port. Depends on abe_pkg for capacity and codes.
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ---------------------------------
//  request   in         in_valid / in_stall    req_type, bit_position, find_value
//  result    out        out_valid / out_stall  status, found_position, bit_value
//  config    in         APB psel / penable     bytes_in_use at address 0
//
// A find reads its bytes in order through the single memory read port, one byte per
// cycle, and stops at the first byte that holds a match. Set and clear go through a
// read-modify-write of one byte and test reads one byte, all via the access state;
// errors go straight to the response state. The block takes one request at a
// time and accepts the next one in the cycle its result is first presented. Reset
// clears the per-byte valid flags at once, so every byte reads as zero afterwards
// without a clearing pass. A stalled result holds in the output register; a finished
// transaction waits in the response state until the output register is free.
module allocation_bitmap_engine_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [abe_pkg::POS_W-1:0]   bit_position,
    input  logic                        find_value,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [abe_pkg::POS_W-1:0]   found_position,
    output logic                        bit_value,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = abe_pkg::ADDR_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_ACCESS = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    // Lowest set bit of a byte; the byte is known to be nonzero when used.
    function automatic logic [2:0] lowest_one(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (b[k])
            begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

    logic [1:0]                  state_reg, state_next;
    logic [abe_pkg::SIZE_W-1:0]  bytes_in_use_reg;
    logic [abe_pkg::SIZE_W-1:0]  size;

    logic [1:0]                  req_reg;
    logic                        want_reg;
    logic [2:0]                  bit_sel_reg;
    logic [AW-1:0]               acc_addr_reg;

    logic [abe_pkg::SIZE_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic                        data_vld_reg;
    logic [AW-1:0]               data_idx_reg;

    logic [1:0]                  res_status_reg, res_status_next;
    logic [abe_pkg::POS_W-1:0]   res_pos_reg, res_pos_next;
    logic                        res_bit_reg, res_bit_next;

    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [abe_pkg::POS_W-1:0]   out_pos_reg;
    logic                        out_bit_reg;

    // Bitmap storage with one valid flag per byte; an unwritten byte reads as zero.
    logic [7:0]                  mem [abe_pkg::MAX_BYTES];
    logic [abe_pkg::MAX_BYTES-1:0] byte_valid_reg;
    logic [7:0]                  rdata_reg;
    logic                        rvalid_reg;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [7:0]                  wr_data;

    logic                        in_accept;
    logic                        out_free;
    logic                        out_load;
    logic [7:0]                  byte_eff;
    logic [7:0]                  match_bits;
    logic [AW+2:0]               found_full;
    logic [abe_pkg::POS_W:0]     limit_bits;
    logic                        pos_bad;

    // A size above the capacity is saturated to the capacity.
    assign size = (int'(bytes_in_use_reg) > abe_pkg::MAX_BYTES) ?
                  abe_pkg::SIZE_W'(abe_pkg::MAX_BYTES) : bytes_in_use_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_RESP) && out_free;

    assign limit_bits = (abe_pkg::POS_W + 1)'({size, 3'b000});
    assign pos_bad    = ({1'b0, bit_position} >= limit_bits);

    assign byte_eff   = rvalid_reg ? rdata_reg : 8'h00;
    assign match_bits = want_reg ? byte_eff : ~byte_eff;
    assign found_full = {data_idx_reg, lowest_one(match_bits)};

    // Configuration port: zero wait states, register 0 only.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == abe_pkg::REG_BYTES_IN_USE) ?
                    {{(32 - abe_pkg::SIZE_W){1'b0}}, bytes_in_use_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_use_reg <= abe_pkg::SIZE_W'(64);
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == abe_pkg::REG_BYTES_IN_USE))
        begin
            bytes_in_use_reg <= pwdata[abe_pkg::SIZE_W-1:0];
        end
    end

    // Read port: the request address on acceptance, the scan counter during a find.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = AW'(bit_position >> 3);
        if (in_accept)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(bit_position >> 3);
        end
        else if (state_reg == S_SCAN)
        begin
            rd_en   = (issue_cnt_reg < size);
            rd_addr = AW'(issue_cnt_reg);
        end
    end

    assign wr_en = (state_reg == S_ACCESS) &&
                   ((req_reg == abe_pkg::REQ_SET) || (req_reg == abe_pkg::REQ_CLEAR));

    always_comb
    begin
        wr_data = byte_eff;
        if (req_reg == abe_pkg::REQ_SET)
        begin
            wr_data[bit_sel_reg] = 1'b1;
        end
        else
        begin
            wr_data[bit_sel_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[acc_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvalid_reg <= byte_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                byte_valid_reg[acc_addr_reg] <= 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_bit_next    = res_bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_status_next = abe_pkg::STAT_ERROR;
                    res_pos_next    = '0;
                    res_bit_next    = 1'b0;
                    issue_cnt_next  = '0;
                    if (size == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else if (req_type == abe_pkg::REQ_FIND)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (pos_bad)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_ACCESS;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (data_vld_reg && (match_bits != 8'h00))
                begin
                    res_status_next = abe_pkg::STAT_OK;
                    res_pos_next    = abe_pkg::POS_W'(found_full);
                    state_next      = S_RESP;
                end
                else if (data_vld_reg && (issue_cnt_reg == size))
                begin
                    res_status_next = abe_pkg::STAT_NOT_FOUND;
                    state_next      = S_RESP;
                end
            end
            S_ACCESS:
            begin
                res_status_next = abe_pkg::STAT_OK;
                if (req_reg == abe_pkg::REQ_TEST)
                begin
                    res_bit_next = byte_eff[bit_sel_reg];
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            data_vld_reg  <= (state_reg == S_SCAN) && rd_en;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_bit_reg    <= res_bit_next;
        if (rd_en)
        begin
            data_idx_reg <= rd_addr;
        end
        if (in_accept)
        begin
            req_reg      <= req_type;
            want_reg     <= find_value;
            bit_sel_reg  <= bit_position[2:0];
            acc_addr_reg <= AW'(bit_position >> 3);
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_bit_reg    <= res_bit_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_position = out_pos_reg;
    assign bit_value      = out_bit_reg;

    // A new result appears only when the sequencer leaves its response state.
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside the response state");

    // A failed transaction carries no position and no bit.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != abe_pkg::STAT_OK) |->
        (out_pos_reg == '0) && !out_bit_reg)
        else $error("failed result carries payload");

    // The scan never reads past the bytes in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= size))
        else $error("scan counter beyond size");

    // The bitmap is only written in the access state of a set or clear.
    a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_ACCESS) && (req_reg != abe_pkg::REQ_TEST))
        else $error("bitmap written by a test or outside access");

endmodule
